FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/hcrp_pkg.sv
// types, field tags and status codes of the hvcC record parser
// no dependencies
package hcrp_pkg;

  localparam int MAX_RES = 5;
  localparam int CNT_W   = 3;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ARR_HDR  = 3'd1,
    PH_ARR_CNT  = 3'd2,
    PH_UNIT_LEN = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  localparam logic [4:0] TAG_CFG_VERSION    = 5'd0;
  localparam logic [4:0] TAG_PROFILE_SPACE  = 5'd1;
  localparam logic [4:0] TAG_TIER_FLAG      = 5'd2;
  localparam logic [4:0] TAG_PROFILE_IDC    = 5'd3;
  localparam logic [4:0] TAG_COMPAT_FLAGS   = 5'd4;
  localparam logic [4:0] TAG_CONSTR_FLAGS   = 5'd5;
  localparam logic [4:0] TAG_LEVEL_IDC      = 5'd6;
  localparam logic [4:0] TAG_MIN_SPATIAL    = 5'd7;
  localparam logic [4:0] TAG_PARALLELISM    = 5'd8;
  localparam logic [4:0] TAG_CHROMA_FORMAT  = 5'd9;
  localparam logic [4:0] TAG_DEPTH_LUMA     = 5'd10;
  localparam logic [4:0] TAG_DEPTH_CHROMA   = 5'd11;
  localparam logic [4:0] TAG_AVG_FRAME_RATE = 5'd12;
  localparam logic [4:0] TAG_CONST_FRAME    = 5'd13;
  localparam logic [4:0] TAG_TEMP_LAYERS    = 5'd14;
  localparam logic [4:0] TAG_TEMP_NESTED    = 5'd15;
  localparam logic [4:0] TAG_LENGTH_SIZE    = 5'd16;
  localparam logic [4:0] TAG_NUM_ARRAYS     = 5'd17;
  localparam logic [4:0] TAG_ARR_COMPLETE   = 5'd18;
  localparam logic [4:0] TAG_NAL_TYPE       = 5'd19;
  localparam logic [4:0] TAG_NUM_NALUS      = 5'd20;
  localparam logic [4:0] TAG_NALU_LENGTH    = 5'd21;
  localparam logic [4:0] TAG_PAYLOAD        = 5'd22;
  localparam logic [4:0] TAG_STATUS         = 5'd23;

  localparam logic [47:0] ST_OK    = 48'd0;
  localparam logic [47:0] ST_TRAIL = 48'd1;
  localparam logic [47:0] ST_TRUNC = 48'd2;

  typedef struct packed {
    logic [4:0]  tag;
    logic [47:0] value;
    logic [7:0]  arr;
    logic [15:0] unit;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]      cnt;
  } batch_t;

  function automatic result_t mk_res(logic [4:0] tag, logic [47:0] value,
                                     logic [7:0] arr, logic [15:0] unit);
    result_t r;
    r.tag   = tag;
    r.value = value;
    r.arr   = arr;
    r.unit  = unit;
    return r;
  endfunction

endpackage

FILE: hdl/hcrp_parser.sv
// parse state of the hvcC record and the result batch of one input byte
// depends on hcrp_pkg
module hcrp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output hcrp_pkg::batch_t batch
);

  hcrp_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  bc_r,   bc_nxt;
  logic [47:0] sh_r,   sh_nxt;
  logic [7:0]  al_r,   al_nxt;
  logic [7:0]  ai_r,   ai_nxt;
  logic [15:0] ul_r,   ul_nxt;
  logic [15:0] ui_r,   ui_nxt;
  logic [15:0] pl_r,   pl_nxt;
  logic        ovr_r,  ovr_nxt;

  logic [hcrp_pkg::CNT_W-1:0] n;
  logic        fin_unit;
  logic        fin_arr;
  logic [47:0] st;
  logic [7:0]  b;

  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    sh_nxt    = sh_r;
    al_nxt    = al_r;
    ai_nxt    = ai_r;
    ul_nxt    = ul_r;
    ui_nxt    = ui_r;
    pl_nxt    = pl_r;
    ovr_nxt   = ovr_r;
    batch     = '0;
    n         = '0;
    fin_unit  = 1'b0;
    fin_arr   = 1'b0;
    st        = hcrp_pkg::ST_OK;
    b         = in_byte;

    unique case (phase_r)
      hcrp_pkg::PH_HEADER: begin
        sh_nxt = {sh_r[39:0], b};
        bc_nxt = bc_r + 5'd1;
        unique case (bc_r)
          5'd0: begin
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_CFG_VERSION, 48'(b), '0, '0);
            n = n + 3'd1;
          end
          5'd1: begin
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_PROFILE_SPACE, 48'(b[7:6]), '0, '0);
            n = n + 3'd1;
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_TIER_FLAG, 48'(b[5]), '0, '0);
            n = n + 3'd1;
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_PROFILE_IDC, 48'(b[4:0]), '0, '0);
            n = n + 3'd1;
          end
          5'd5: begin
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_COMPAT_FLAGS,
                                            48'(sh_nxt[31:0]), '0, '0);
            n = n + 3'd1;
          end
          5'd11: begin
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_CONSTR_FLAGS, sh_nxt, '0, '0);
            n = n + 3'd1;
          end
          5'd12: begin
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_LEVEL_IDC, 48'(b), '0, '0);
            n = n + 3'd1;
          end
          5'd14: begin
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_MIN_SPATIAL,
                                            48'(sh_nxt[11:0]), '0, '0);
            n = n + 3'd1;
          end
          5'd15: begin
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_PARALLELISM, 48'(b[1:0]), '0, '0);
            n = n + 3'd1;
          end
          5'd16: begin
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_CHROMA_FORMAT, 48'(b[1:0]), '0, '0);
            n = n + 3'd1;
          end
          5'd17: begin
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_DEPTH_LUMA, 48'(b[2:0]), '0, '0);
            n = n + 3'd1;
          end
          5'd18: begin
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_DEPTH_CHROMA, 48'(b[2:0]), '0, '0);
            n = n + 3'd1;
          end
          5'd20: begin
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_AVG_FRAME_RATE,
                                            48'(sh_nxt[15:0]), '0, '0);
            n = n + 3'd1;
          end
          5'd21: begin
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_CONST_FRAME, 48'(b[7:6]), '0, '0);
            n = n + 3'd1;
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_TEMP_LAYERS, 48'(b[5:3]), '0, '0);
            n = n + 3'd1;
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_TEMP_NESTED, 48'(b[2]), '0, '0);
            n = n + 3'd1;
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_LENGTH_SIZE, 48'(b[1:0]), '0, '0);
            n = n + 3'd1;
          end
          5'd22: begin
            batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_NUM_ARRAYS, 48'(b), '0, '0);
            n = n + 3'd1;
            al_nxt    = b;
            ai_nxt    = '0;
            bc_nxt    = '0;
            phase_nxt = (b == 8'd0) ? hcrp_pkg::PH_DONE : hcrp_pkg::PH_ARR_HDR;
          end
          default: begin
          end
        endcase
      end
      hcrp_pkg::PH_ARR_HDR: begin
        batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_ARR_COMPLETE, 48'(b[7]), ai_r, '0);
        n = n + 3'd1;
        batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_NAL_TYPE, 48'(b[5:0]), ai_r, '0);
        n = n + 3'd1;
        bc_nxt    = '0;
        phase_nxt = hcrp_pkg::PH_ARR_CNT;
      end
      hcrp_pkg::PH_ARR_CNT: begin
        sh_nxt = {sh_r[39:0], b};
        if (bc_r == 5'd0) begin
          bc_nxt = 5'd1;
        end else begin
          ul_nxt = sh_nxt[15:0];
          ui_nxt = '0;
          batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_NUM_NALUS, 48'(sh_nxt[15:0]), ai_r, '0);
          n = n + 3'd1;
          bc_nxt = '0;
          if (sh_nxt[15:0] == 16'd0) begin
            fin_arr = 1'b1;
          end else begin
            phase_nxt = hcrp_pkg::PH_UNIT_LEN;
          end
        end
      end
      hcrp_pkg::PH_UNIT_LEN: begin
        sh_nxt = {sh_r[39:0], b};
        if (bc_r == 5'd0) begin
          bc_nxt = 5'd1;
        end else begin
          pl_nxt = sh_nxt[15:0];
          batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_NALU_LENGTH, 48'(sh_nxt[15:0]),
                                          ai_r, ui_r);
          n = n + 3'd1;
          bc_nxt = '0;
          if (sh_nxt[15:0] == 16'd0) begin
            fin_unit = 1'b1;
          end else begin
            phase_nxt = hcrp_pkg::PH_PAYLOAD;
          end
        end
      end
      hcrp_pkg::PH_PAYLOAD: begin
        batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_PAYLOAD, 48'(b), ai_r, ui_r);
        n = n + 3'd1;
        pl_nxt = pl_r - 16'd1;
        if (pl_nxt == 16'd0) begin
          fin_unit = 1'b1;
        end
      end
      default: begin
        ovr_nxt = 1'b1;
      end
    endcase

    if (fin_unit) begin
      ui_nxt = ui_nxt + 16'd1;
      ul_nxt = ul_nxt - 16'd1;
      bc_nxt = '0;
      if (ul_nxt == 16'd0) begin
        fin_arr = 1'b1;
      end else begin
        phase_nxt = hcrp_pkg::PH_UNIT_LEN;
      end
    end

    if (fin_arr) begin
      al_nxt    = al_r - 8'd1;
      ai_nxt    = ai_r + 8'd1;
      bc_nxt    = '0;
      phase_nxt = (al_nxt == 8'd0) ? hcrp_pkg::PH_DONE : hcrp_pkg::PH_ARR_HDR;
    end

    if (in_last) begin
      if (ovr_nxt) begin
        st = hcrp_pkg::ST_TRAIL;
      end else if (phase_nxt == hcrp_pkg::PH_DONE) begin
        st = hcrp_pkg::ST_OK;
      end else begin
        st = hcrp_pkg::ST_TRUNC;
      end
      batch.res[n] = hcrp_pkg::mk_res(hcrp_pkg::TAG_STATUS, st, '0, '0);
      n = n + 3'd1;
      phase_nxt = hcrp_pkg::PH_HEADER;
      bc_nxt    = '0;
      sh_nxt    = '0;
      al_nxt    = '0;
      ai_nxt    = '0;
      ul_nxt    = '0;
      ui_nxt    = '0;
      pl_nxt    = '0;
      ovr_nxt   = 1'b0;
    end

    batch.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcrp_pkg::PH_HEADER;
      bc_r    <= '0;
      sh_r    <= '0;
      al_r    <= '0;
      ai_r    <= '0;
      ul_r    <= '0;
      ui_r    <= '0;
      pl_r    <= '0;
      ovr_r   <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      sh_r    <= sh_nxt;
      al_r    <= al_nxt;
      ai_r    <= ai_nxt;
      ul_r    <= ul_nxt;
      ui_r    <= ui_nxt;
      pl_r    <= pl_nxt;
      ovr_r   <= ovr_nxt;
    end
  end

endmodule

FILE: hdl/hevc_config_record_parser.sv
// top level of the hvcC record parser: byte stream in, tagged field stream out
// depends on hcrp_pkg and hcrp_parser
//
// channel  dir  tdata                             tuser      tlast
// in_      in   data_byte[7:0]                    -          last_byte
// out_     out  field_value, array_number,        field_tag  run_end
//               unit_number
//
// one byte is taken per cycle while the output queue is empty or its last result is leaving
// a byte with n results holds the input until its last result leaves (up to 5 results)
// results leave one per cycle while out_tready is high, from a five-entry queue filled in one step
// rst_n clears the parse state and empties the queue
module hevc_config_record_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // field_value[47:0], array_number[55:48], unit_number[71:56]
  output logic [4:0]  out_tuser,  // field_tag[4:0]
  output logic        out_tlast
);

  hcrp_pkg::batch_t batch;
  hcrp_pkg::result_t [hcrp_pkg::MAX_RES-1:0] q_r;
  logic [hcrp_pkg::CNT_W-1:0] qcnt_r;
  logic in_fire;
  logic out_fire;

  assign out_fire   = out_tvalid & out_tready;
  assign in_tready  = (qcnt_r == '0) || ((qcnt_r == 3'd1) && out_tready);
  assign in_fire    = in_tvalid & in_tready;
  assign out_tvalid = (qcnt_r != '0);
  assign out_tlast  = (qcnt_r == 3'd1);
  assign out_tuser  = q_r[0].tag;
  assign out_tdata  = {q_r[0].unit, q_r[0].arr, q_r[0].value};

  hcrp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .batch   (batch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= '0;
    end else if (in_fire) begin
      qcnt_r <= batch.cnt;
    end else if (out_fire) begin
      qcnt_r <= qcnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_r <= batch.res;
    end else if (out_fire) begin
      q_r <= {hcrp_pkg::result_t'('0), q_r[hcrp_pkg::MAX_RES-1:1]};
    end
  end

endmodule

FILE: hdl/hcrp_checker.sv
// port-level checks of the hvcC record parser, bound to the top level
// depends on hcrp_pkg and assert_macros.svh
`include "assert_macros.svh"

module hcrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [4:0]  out_tuser,
  input logic        out_tlast
);

  logic        out_stall;
  logic        is_status;
  logic [77:0] out_word;
  logic        status_ok;

  assign out_stall = out_tvalid & ~out_tready;
  assign is_status = out_tvalid && (out_tuser == hcrp_pkg::TAG_STATUS);
  assign out_word  = {out_tlast, out_tuser, out_tdata};
  assign status_ok = (out_tdata[47:0] <= hcrp_pkg::ST_TRUNC) && (out_tdata[71:48] == 24'd0);

  `ASSERT_NEXT(a_out_valid_held, clk, rst_n, out_stall, out_tvalid, "out valid dropped under stall")
  `ASSERT_NEXT(a_out_data_held, clk, rst_n, out_stall, $stable(out_word), "out request changed")
  `ASSERT_IMPL(a_status_last, clk, rst_n, is_status, out_tlast, "status not last of its run")
  `ASSERT_IMPL(a_status_code, clk, rst_n, is_status, status_ok, "bad status request")
  `ASSERT_IMPL(a_idle_ready, clk, rst_n, !out_tvalid, in_tready, "input blocked with empty queue")

endmodule

bind hevc_config_record_parser hcrp_checker u_hcrp_checker (.*);

FILE: test/tb.sv
// testbench for hevc_config_record_parser: sends hvcC records byte by byte and
// checks every tagged result against an in-bench model of the parser
// depends on hcrp_pkg and hevc_config_record_parser
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0]  tag;
    logic [47:0] value;
    logic [7:0]  arr;
    logic [15:0] unit;
    logic        run_end;
  } field_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [71:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        out_tlast;

  hevc_config_record_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // parser model state
  hcrp_pkg::phase_t parse_phase = hcrp_pkg::PH_HEADER;
  logic [4:0]  hdr_count = '0;
  logic [47:0] shift_reg = '0;
  logic [7:0]  arrays_left = '0;
  logic [7:0]  array_idx = '0;
  logic [15:0] units_left = '0;
  logic [15:0] unit_idx = '0;
  logic [15:0] payload_left = '0;
  logic        overrun = 1'b0;

  field_rec_t  expected_fields[$];
  field_rec_t  byte_fields[$];
  logic [7:0]  record_bytes[$];
  int          err_count = 0;
  int          bytes_sent = 0;
  bit          no_idle = 1'b0;
  int          stall_left = 0;
  field_rec_t  want;
  field_rec_t  got;

  function automatic void add_field(logic [4:0] tag, logic [47:0] value,
                                    logic [7:0] arr, logic [15:0] unit);
    field_rec_t f;
    if (byte_fields.size() >= hcrp_pkg::MAX_RES) return;
    f.tag = tag;
    f.value = value;
    f.arr = arr;
    f.unit = unit;
    f.run_end = 1'b0;
    byte_fields = {byte_fields, f};
  endfunction

  function automatic void add_byte(logic [7:0] v);
    record_bytes = {record_bytes, v};
  endfunction

  function automatic void clear_parser();
    parse_phase = hcrp_pkg::PH_HEADER;
    hdr_count = '0;
    shift_reg = '0;
    arrays_left = '0;
    array_idx = '0;
    units_left = '0;
    unit_idx = '0;
    payload_left = '0;
    overrun = 1'b0;
  endfunction

  function automatic void close_array();
    arrays_left = arrays_left - 8'd1;
    array_idx = array_idx + 8'd1;
    hdr_count = '0;
    parse_phase = (arrays_left == 8'd0) ? hcrp_pkg::PH_DONE : hcrp_pkg::PH_ARR_HDR;
  endfunction

  function automatic void close_unit();
    unit_idx = unit_idx + 16'd1;
    units_left = units_left - 16'd1;
    hdr_count = '0;
    if (units_left == 16'd0) close_array();
    else parse_phase = hcrp_pkg::PH_UNIT_LEN;
  endfunction

  function automatic void header_step(logic [7:0] b);
    shift_reg = {shift_reg[39:0], b};
    case (hdr_count)
      5'd0: add_field(hcrp_pkg::TAG_CFG_VERSION, 48'(b), '0, '0);
      5'd1: begin
        add_field(hcrp_pkg::TAG_PROFILE_SPACE, 48'(b[7:6]), '0, '0);
        add_field(hcrp_pkg::TAG_TIER_FLAG, 48'(b[5]), '0, '0);
        add_field(hcrp_pkg::TAG_PROFILE_IDC, 48'(b[4:0]), '0, '0);
      end
      5'd5:  add_field(hcrp_pkg::TAG_COMPAT_FLAGS, 48'(shift_reg[31:0]), '0, '0);
      5'd11: add_field(hcrp_pkg::TAG_CONSTR_FLAGS, shift_reg, '0, '0);
      5'd12: add_field(hcrp_pkg::TAG_LEVEL_IDC, 48'(b), '0, '0);
      5'd14: add_field(hcrp_pkg::TAG_MIN_SPATIAL, 48'(shift_reg[11:0]), '0, '0);
      5'd15: add_field(hcrp_pkg::TAG_PARALLELISM, 48'(b[1:0]), '0, '0);
      5'd16: add_field(hcrp_pkg::TAG_CHROMA_FORMAT, 48'(b[1:0]), '0, '0);
      5'd17: add_field(hcrp_pkg::TAG_DEPTH_LUMA, 48'(b[2:0]), '0, '0);
      5'd18: add_field(hcrp_pkg::TAG_DEPTH_CHROMA, 48'(b[2:0]), '0, '0);
      5'd20: add_field(hcrp_pkg::TAG_AVG_FRAME_RATE, 48'(shift_reg[15:0]), '0, '0);
      5'd21: begin
        add_field(hcrp_pkg::TAG_CONST_FRAME, 48'(b[7:6]), '0, '0);
        add_field(hcrp_pkg::TAG_TEMP_LAYERS, 48'(b[5:3]), '0, '0);
        add_field(hcrp_pkg::TAG_TEMP_NESTED, 48'(b[2]), '0, '0);
        add_field(hcrp_pkg::TAG_LENGTH_SIZE, 48'(b[1:0]), '0, '0);
      end
      5'd22: begin
        add_field(hcrp_pkg::TAG_NUM_ARRAYS, 48'(b), '0, '0);
        arrays_left = b;
        array_idx = '0;
        parse_phase = (b == 8'd0) ? hcrp_pkg::PH_DONE : hcrp_pkg::PH_ARR_HDR;
      end
      default: ;
    endcase
    if (hdr_count == 5'd22) hdr_count = '0;
    else hdr_count = hdr_count + 5'd1;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last);
    byte_fields.delete();
    case (parse_phase)
      hcrp_pkg::PH_HEADER: header_step(b);
      hcrp_pkg::PH_ARR_HDR: begin
        add_field(hcrp_pkg::TAG_ARR_COMPLETE, 48'(b[7]), array_idx, '0);
        add_field(hcrp_pkg::TAG_NAL_TYPE, 48'(b[5:0]), array_idx, '0);
        hdr_count = '0;
        parse_phase = hcrp_pkg::PH_ARR_CNT;
      end
      hcrp_pkg::PH_ARR_CNT: begin
        shift_reg = {shift_reg[39:0], b};
        if (hdr_count == 5'd0) begin
          hdr_count = 5'd1;
        end else begin
          units_left = shift_reg[15:0];
          unit_idx = '0;
          add_field(hcrp_pkg::TAG_NUM_NALUS, 48'(units_left), array_idx, '0);
          hdr_count = '0;
          if (units_left == 16'd0) close_array();
          else parse_phase = hcrp_pkg::PH_UNIT_LEN;
        end
      end
      hcrp_pkg::PH_UNIT_LEN: begin
        shift_reg = {shift_reg[39:0], b};
        if (hdr_count == 5'd0) begin
          hdr_count = 5'd1;
        end else begin
          payload_left = shift_reg[15:0];
          add_field(hcrp_pkg::TAG_NALU_LENGTH, 48'(payload_left), array_idx, unit_idx);
          hdr_count = '0;
          if (payload_left == 16'd0) close_unit();
          else parse_phase = hcrp_pkg::PH_PAYLOAD;
        end
      end
      hcrp_pkg::PH_PAYLOAD: begin
        add_field(hcrp_pkg::TAG_PAYLOAD, 48'(b), array_idx, unit_idx);
        payload_left = payload_left - 16'd1;
        if (payload_left == 16'd0) close_unit();
      end
      default: overrun = 1'b1;
    endcase
    if (last) begin
      add_field(hcrp_pkg::TAG_STATUS,
                overrun ? hcrp_pkg::ST_TRAIL :
                ((parse_phase == hcrp_pkg::PH_DONE) ? hcrp_pkg::ST_OK : hcrp_pkg::ST_TRUNC),
                '0, '0);
      clear_parser();
    end
    foreach (byte_fields[i]) begin
      if (i == byte_fields.size() - 1) byte_fields[i].run_end = 1'b1;
      expected_fields = {expected_fields, byte_fields[i]};
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_record();
    foreach (record_bytes[i]) send_byte(record_bytes[i], i == record_bytes.size() - 1);
  endtask

  task automatic build_header(logic [7:0] num_arrays);
    repeat (22) add_byte(8'($urandom));
    add_byte(num_arrays);
  endtask

  task automatic test_header_extremes();
    // all-ones header, no arrays, then an extra byte flagged last
    record_bytes.delete();
    repeat (22) add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'hFF);
    send_record();
  endtask

  task automatic test_truncated_record();
    record_bytes.delete();
    add_byte(8'h00);
    add_byte(8'h00);
    send_record();
  endtask

  task automatic test_random_records(int target);
    int mode;
    int units;
    int len;
    int cut;
    while (bytes_sent < target) begin
      mode = $urandom_range(0, 99);
      record_bytes.delete();
      if (mode < 15) begin
        repeat ($urandom_range(1, 40)) add_byte(8'($urandom));
      end else begin
        build_header(8'($urandom_range(0, 3)));
        repeat (record_bytes[22]) begin
          add_byte(8'($urandom));
          units = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
          add_byte(8'(units >> 8));
          add_byte(8'(units));
          repeat (units) begin
            len = $urandom_range(0, 5);
            add_byte(8'(len >> 8));
            add_byte(8'(len));
            repeat (len) add_byte(8'($urandom));
          end
        end
        if (mode < 30) begin
          cut = $urandom_range(1, record_bytes.size() - 1);
          while (record_bytes.size() > cut) void'(record_bytes.pop_back());
        end else if (mode < 40) begin
          repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
        end
      end
      no_idle = ($urandom_range(0, 3) == 0);
      send_record();
    end
  endtask

  task automatic log_mismatch(string what);
    err_count++;
    if (err_count <= 10)
      $display("%s: tag %0d/%0d value %h/%h array %0d/%0d unit %0d/%0d end %b/%b (exp/act)",
               what, want.tag, got.tag, want.value, got.value, want.arr, got.arr,
               want.unit, got.unit, want.run_end, got.run_end);
  endtask

  always @(negedge clk) begin
    if (no_idle) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.tag = out_tuser;
      got.value = out_tdata[47:0];
      got.arr = out_tdata[55:48];
      got.unit = out_tdata[71:56];
      got.run_end = out_tlast;
      if (expected_fields.size() == 0) begin
        want = '0;
        log_mismatch("unexpected result");
      end else begin
        want = expected_fields.pop_front();
        if (got != want) log_mismatch("mismatch");
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_header_extremes();
    test_truncated_record();
    test_random_records(430);
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0 && expected_fields.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
